>>> hw/rtl/source_text_tokenizer_unit_defines.svh
// ---------------------------------------------------------------------------
// source_text_tokenizer_unit_defines
// assertion macros shared by the tokenizer rtl
// ---------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_UNIT_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define STT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define STT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/stt_pkg.sv
// ---------------------------------------------------------------------------
// stt_pkg
// shared types, codes and character constants of the source text tokenizer
// ---------------------------------------------------------------------------
package stt_pkg;

	// offsets and line numbers
	localparam int POS_BITS = 24;
	localparam int OUT_BITS = 24;
	typedef logic [POS_BITS-1:0] pos_t;
	typedef logic [OUT_BITS-1:0] opos_t;
	localparam pos_t  POS_MAX = '1;
	localparam opos_t OUT_MAX = '1;

	typedef logic [7:0] byte_t;

	// result queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	// record codes
	localparam logic [1:0] REC_TOKEN = 2'd0;
	localparam logic [1:0] REC_VALUE = 2'd1;
	localparam logic [1:0] REC_ERROR = 2'd2;

	// error codes
	localparam logic ERR_NUMBER = 1'b0;
	localparam logic ERR_STRING = 1'b1;

	// token kinds
	localparam logic [4:0] K_ADD      = 5'd0;
	localparam logic [4:0] K_SUB      = 5'd1;
	localparam logic [4:0] K_MUL      = 5'd2;
	localparam logic [4:0] K_DIV      = 5'd3;
	localparam logic [4:0] K_LPAREN   = 5'd4;
	localparam logic [4:0] K_RPAREN   = 5'd5;
	localparam logic [4:0] K_LBRACKET = 5'd6;
	localparam logic [4:0] K_RBRACKET = 5'd7;
	localparam logic [4:0] K_LBRACE   = 5'd8;
	localparam logic [4:0] K_RBRACE   = 5'd9;
	localparam logic [4:0] K_PERIOD   = 5'd10;
	localparam logic [4:0] K_COMMA    = 5'd11;
	localparam logic [4:0] K_COLON    = 5'd12;
	localparam logic [4:0] K_SEMI     = 5'd13;
	localparam logic [4:0] K_LT       = 5'd14;
	localparam logic [4:0] K_GT       = 5'd16;
	localparam logic [4:0] K_NOT      = 5'd18;
	localparam logic [4:0] K_EQ       = 5'd20;
	localparam logic [4:0] K_IDENT    = 5'd22;
	localparam logic [4:0] K_INT      = 5'd23;
	localparam logic [4:0] K_FLOAT    = 5'd24;
	localparam logic [4:0] K_STR      = 5'd25;
	localparam logic [4:0] K_CHAR     = 5'd26;
	localparam logic [4:0] K_EOF      = 5'd27;

	// characters
	localparam byte_t CH_PLUS   = "+";
	localparam byte_t CH_MINUS  = "-";
	localparam byte_t CH_STAR   = "*";
	localparam byte_t CH_LPAR   = "(";
	localparam byte_t CH_RPAR   = ")";
	localparam byte_t CH_LBRK   = "[";
	localparam byte_t CH_RBRK   = "]";
	localparam byte_t CH_LBRC   = "{";
	localparam byte_t CH_RBRC   = "}";
	localparam byte_t CH_DOT    = ".";
	localparam byte_t CH_COMMA  = ",";
	localparam byte_t CH_COLON  = ":";
	localparam byte_t CH_SEMI   = ";";
	localparam byte_t CH_SLASH  = "/";
	localparam byte_t CH_LT     = "<";
	localparam byte_t CH_GT     = ">";
	localparam byte_t CH_BANG   = "!";
	localparam byte_t CH_EQ     = "=";
	localparam byte_t CH_DQUOTE = 8'h22;
	localparam byte_t CH_SQUOTE = 8'h27;
	localparam byte_t CH_BSLASH = 8'h5C;
	localparam byte_t CH_USCORE = "_";
	localparam byte_t CH_UC_A   = "A";
	localparam byte_t CH_UC_Z   = "Z";
	localparam byte_t CH_LC_A   = "a";
	localparam byte_t CH_LC_Z   = "z";
	localparam byte_t CH_ZERO   = "0";
	localparam byte_t CH_NINE   = "9";
	localparam byte_t CH_LC_N   = "n";
	localparam byte_t CH_LC_T   = "t";
	localparam byte_t CH_NL     = 8'd10;
	localparam byte_t CH_TAB    = 8'd9;
	localparam byte_t CH_NUL    = 8'd0;

	// lexer modes
	typedef enum logic [3:0] {
		M_IDLE,
		M_OP,
		M_IDENT,
		M_NUM,
		M_STR,
		M_STR_ESC,
		M_CHAR_OPEN,
		M_CHAR_ESC,
		M_CHAR_CLOSE,
		M_COMMENT
	} mode_t;

	// one result record
	typedef struct packed {
		logic [1:0] record;
		logic [4:0] kind;
		opos_t      start_pos;
		opos_t      end_pos;
		opos_t      line_no;
		byte_t      value_byte;
		logic       error_code;
		logic       last;
	} res_t;

	// results of one word pushed into the queue
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} push_t;

	// clamp an internal offset to the output width
	function automatic opos_t o24(pos_t v);
		logic [63:0] w;
		w = 64'(v);
		if (w > 64'(OUT_MAX))
			return OUT_MAX;
		return w[OUT_BITS-1:0];
	endfunction

endpackage

>>> hw/rtl/stt_in_if.sv
// ---------------------------------------------------------------------------
// stt_in_if
// source text channel: one byte or end-of-text mark per word
// ---------------------------------------------------------------------------
interface stt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_text;

	modport source (output valid, output ch, output end_of_text, input ready);
	modport sink (input valid, input ch, input end_of_text, output ready);
endinterface

>>> hw/rtl/stt_out_if.sv
// ---------------------------------------------------------------------------
// stt_out_if
// token channel: one token, value byte or error record per word
// ---------------------------------------------------------------------------
interface stt_out_if import stt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [1:0]          record;
	logic [4:0]          kind;
	logic [OUT_BITS-1:0] start_pos;
	logic [OUT_BITS-1:0] end_pos;
	logic [OUT_BITS-1:0] line_no;
	logic [7:0]          value_byte;
	logic                error_code;
	logic                last;

	modport source (output valid, output record, output kind, output start_pos,
		output end_pos, output line_no, output value_byte, output error_code,
		output last, input ready);
	modport sink (input valid, input record, input kind, input start_pos,
		input end_pos, input line_no, input value_byte, input error_code,
		input last, output ready);
endinterface

>>> hw/rtl/stt_result_queue.sv
// ---------------------------------------------------------------------------
// stt_result_queue
// small queue of result records, takes up to two per cycle, gives one while tokens.ready
// ---------------------------------------------------------------------------
`include "source_text_tokenizer_unit_defines.svh"

module stt_result_queue import stt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  push_t            push,
	output logic             space,
	stt_out_if.source        tokens
);

	res_t                 entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] head_q;
	logic [QPTR_BITS-1:0] tail_q;
	logic [QPTR_BITS:0]   count_q;
	logic                 pop;

	// room for a full pair of results
	assign space = (count_q <= (QPTR_BITS+1)'(QUEUE_DEPTH - 2));
	assign pop   = tokens.valid && tokens.ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + QPTR_BITS'(push.cnt);
			head_q  <= head_q + QPTR_BITS'(pop);
			count_q <= count_q + (QPTR_BITS+1)'(push.cnt) - (QPTR_BITS+1)'(pop);
		end
	end

	// record storage
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0)
			entry_q[tail_q] <= push.r0;
		if (push.cnt == 2'd2)
			entry_q[tail_q + QPTR_BITS'(1)] <= push.r1;
	end

	// head record to the channel
	assign tokens.valid      = (count_q != '0);
	assign tokens.record     = entry_q[head_q].record;
	assign tokens.kind       = entry_q[head_q].kind;
	assign tokens.start_pos  = entry_q[head_q].start_pos;
	assign tokens.end_pos    = entry_q[head_q].end_pos;
	assign tokens.line_no    = entry_q[head_q].line_no;
	assign tokens.value_byte = entry_q[head_q].value_byte;
	assign tokens.error_code = entry_q[head_q].error_code;
	assign tokens.last       = entry_q[head_q].last;

	`STT_ASSERT_NOW(a_queue_bound, clk, arst_n, 1'b1, count_q <= (QPTR_BITS+1)'(QUEUE_DEPTH), "result queue overfilled")
	`STT_ASSERT_NOW(a_push_room, clk, arst_n, push.cnt != 2'd0, space, "results pushed without room")

endmodule

>>> hw/rtl/stt_lexer.sv
// ---------------------------------------------------------------------------
// stt_lexer
// tokenizer state and the per-byte mode transition with its result records
// ---------------------------------------------------------------------------
`include "source_text_tokenizer_unit_defines.svh"

module stt_lexer import stt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	input  byte_t ch,
	input  logic  end_of_text,
	input  logic  space,
	output push_t push
);

	mode_t      mode_q, mode_n;
	byte_t      pending_op_q, pending_op_n;
	pos_t       token_start_q, token_start_n;
	logic [1:0] dot_count_q, dot_count_n;
	pos_t       position_q, position_n;
	pos_t       line_count_q, line_count_n;
	byte_t      char_value_q, char_value_n;
	logic       halted_q, halted_n;
	pos_t       last_pos_q, last_pos_n;

	logic       adv;
	logic       is_alpha, is_digit, is_alnum, is_opstart;
	logic       op_hit;
	logic [4:0] op_kind;
	logic       num_bad;
	pos_t       line_inc;

	// idle-mode handling of the current byte
	logic       idle_v;
	res_t       idle_r;
	mode_t      idle_mode;
	byte_t      idle_pend;
	pos_t       idle_ts;
	logic [1:0] idle_dot;
	byte_t      idle_char;
	pos_t       idle_line;

	logic       pre_v, sec_v;
	res_t       pre_r, sec_r;

	function automatic pos_t sat_inc(pos_t v);
		return (v == POS_MAX) ? v : v + POS_BITS'(1);
	endfunction

	function automatic byte_t unescape(byte_t c);
		if (c == CH_LC_N)
			return CH_NL;
		if (c == CH_LC_T)
			return CH_TAB;
		if (c == CH_ZERO)
			return CH_NUL;
		return c;
	endfunction

	function automatic logic [4:0] pending_kind(byte_t op, logic with_eq);
		logic [4:0] k;
		unique case (op)
			CH_LT:   k = K_LT;
			CH_GT:   k = K_GT;
			CH_BANG: k = K_NOT;
			CH_EQ:   k = K_EQ;
			default: return K_DIV;
		endcase
		return with_eq ? k + 5'd1 : k;
	endfunction

	function automatic res_t make_res(logic [1:0] rec, logic [4:0] kind, pos_t s, pos_t e,
		pos_t line, byte_t vb, logic ec);
		res_t r;
		r.record     = rec;
		r.kind       = kind;
		r.start_pos  = o24(s);
		r.end_pos    = o24(e);
		r.line_no    = o24(line);
		r.value_byte = vb;
		r.error_code = ec;
		r.last       = 1'b0;
		return r;
	endfunction

	assign adv = item_valid && space && !halted_q;

	// byte classes
	assign is_alpha = ((ch >= CH_UC_A) && (ch <= CH_UC_Z)) ||
		((ch >= CH_LC_A) && (ch <= CH_LC_Z)) || (ch == CH_USCORE);
	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign is_alnum = is_alpha || is_digit;
	assign is_opstart = (ch == CH_SLASH) || (ch == CH_LT) || (ch == CH_GT) ||
		(ch == CH_BANG) || (ch == CH_EQ);
	assign num_bad  = (dot_count_q > 2'd1);
	assign line_inc = sat_inc(line_count_q);

	// single-character operator decode
	always_comb begin
		op_hit  = 1'b1;
		op_kind = K_ADD;
		unique case (ch)
			CH_PLUS:  op_kind = K_ADD;
			CH_MINUS: op_kind = K_SUB;
			CH_STAR:  op_kind = K_MUL;
			CH_LPAR:  op_kind = K_LPAREN;
			CH_RPAR:  op_kind = K_RPAREN;
			CH_LBRK:  op_kind = K_LBRACKET;
			CH_RBRK:  op_kind = K_RBRACKET;
			CH_LBRC:  op_kind = K_LBRACE;
			CH_RBRC:  op_kind = K_RBRACE;
			CH_DOT:   op_kind = K_PERIOD;
			CH_COMMA: op_kind = K_COMMA;
			CH_COLON: op_kind = K_COLON;
			CH_SEMI:  op_kind = K_SEMI;
			default:  op_hit  = 1'b0;
		endcase
	end

	// what a byte does when no token is open
	always_comb begin
		idle_v    = 1'b0;
		idle_r    = make_res(REC_TOKEN, op_kind, position_q, position_q, line_count_q,
			CH_NUL, 1'b0);
		idle_mode = M_IDLE;
		idle_pend = pending_op_q;
		idle_ts   = token_start_q;
		idle_dot  = dot_count_q;
		idle_char = char_value_q;
		idle_line = line_count_q;
		if (op_hit) begin
			idle_v = 1'b1;
		end else if (is_opstart) begin
			idle_pend = ch;
			idle_ts   = position_q;
			idle_mode = M_OP;
		end else if (is_alpha) begin
			idle_v    = 1'b1;
			idle_r    = make_res(REC_VALUE, K_IDENT, position_q, position_q, line_count_q,
				ch, 1'b0);
			idle_ts   = position_q;
			idle_mode = M_IDENT;
		end else if (is_digit) begin
			idle_v    = 1'b1;
			idle_r    = make_res(REC_VALUE, K_INT, position_q, position_q, line_count_q,
				ch, 1'b0);
			idle_ts   = position_q;
			idle_dot  = 2'd0;
			idle_mode = M_NUM;
		end else if (ch == CH_DQUOTE) begin
			idle_ts   = position_q;
			idle_mode = M_STR;
		end else if (ch == CH_SQUOTE) begin
			idle_ts   = position_q;
			idle_char = CH_NUL;
			idle_mode = M_CHAR_OPEN;
		end else if (ch == CH_NL) begin
			idle_line = line_inc;
		end
	end

	// result records of the current word
	always_comb begin
		pre_v = 1'b0;
		sec_v = 1'b0;
		pre_r = make_res(REC_TOKEN, K_IDENT, token_start_q, last_pos_q, line_count_q,
			CH_NUL, 1'b0);
		sec_r = make_res(REC_TOKEN, K_EOF, position_q, position_q, line_count_q,
			CH_NUL, 1'b0);
		if (end_of_text) begin
			sec_v = 1'b1;
			unique case (mode_q)
				M_IDENT: begin
					pre_v = 1'b1;
				end
				M_NUM: begin
					pre_v = 1'b1;
					if (num_bad) begin
						sec_v = 1'b0;
						pre_r = make_res(REC_ERROR, K_INT, token_start_q, position_q,
							line_count_q, CH_NUL, ERR_NUMBER);
					end else begin
						pre_r.kind = (dot_count_q == 2'd0) ? K_INT : K_FLOAT;
					end
				end
				M_OP: begin
					pre_v = 1'b1;
					pre_r = make_res(REC_TOKEN, pending_kind(pending_op_q, 1'b0),
						token_start_q, token_start_q, line_count_q, CH_NUL, 1'b0);
				end
				M_STR, M_STR_ESC: begin
					pre_v = 1'b1;
					sec_v = 1'b0;
					pre_r = make_res(REC_ERROR, K_STR, token_start_q, position_q,
						line_count_q, CH_NUL, ERR_STRING);
				end
				default: begin
				end
			endcase
		end else begin
			sec_r = idle_r;
			unique case (mode_q)
				M_OP: begin
					if (!((pending_op_q == CH_SLASH) && (ch == CH_SLASH))) begin
						pre_v = 1'b1;
						if ((pending_op_q != CH_SLASH) && (ch == CH_EQ)) begin
							pre_r = make_res(REC_TOKEN, pending_kind(pending_op_q, 1'b1),
								token_start_q, position_q, line_count_q, CH_NUL, 1'b0);
						end else begin
							pre_r = make_res(REC_TOKEN, pending_kind(pending_op_q, 1'b0),
								token_start_q, token_start_q, line_count_q, CH_NUL, 1'b0);
							sec_v = idle_v;
						end
					end
				end
				M_IDENT: begin
					pre_v = 1'b1;
					if (is_alnum) begin
						pre_r = make_res(REC_VALUE, K_IDENT, token_start_q, position_q,
							line_count_q, ch, 1'b0);
					end else begin
						sec_v = idle_v;
					end
				end
				M_NUM: begin
					pre_v = 1'b1;
					if (is_digit || (ch == CH_DOT)) begin
						pre_r = make_res(REC_VALUE, K_INT, token_start_q, position_q,
							line_count_q, ch, 1'b0);
					end else if (num_bad) begin
						pre_r = make_res(REC_ERROR, K_INT, token_start_q, position_q,
							line_count_q, CH_NUL, ERR_NUMBER);
					end else begin
						pre_r.kind = (dot_count_q == 2'd0) ? K_INT : K_FLOAT;
						sec_v = idle_v;
					end
				end
				M_STR: begin
					if (ch == CH_DQUOTE) begin
						pre_v = 1'b1;
						pre_r = make_res(REC_TOKEN, K_STR, token_start_q, position_q,
							line_count_q, CH_NUL, 1'b0);
					end else if (ch != CH_BSLASH) begin
						pre_v = 1'b1;
						pre_r = make_res(REC_VALUE, K_STR, token_start_q, position_q,
							line_count_q, ch, 1'b0);
					end
				end
				M_STR_ESC: begin
					pre_v = 1'b1;
					pre_r = make_res(REC_VALUE, K_STR, token_start_q, position_q,
						line_count_q, unescape(ch), 1'b0);
				end
				M_CHAR_CLOSE: begin
					pre_v = 1'b1;
					pre_r = make_res(REC_TOKEN, K_CHAR, token_start_q, position_q,
						line_count_q, char_value_q, 1'b0);
				end
				M_IDLE: begin
					sec_v = idle_v;
				end
				default: begin
				end
			endcase
		end
	end

	// pack the records in order, flag the final one
	always_comb begin
		push.cnt = 2'd0;
		push.r0  = pre_v ? pre_r : sec_r;
		push.r1  = sec_r;
		if (adv) begin
			if (pre_v)
				push.cnt = sec_v ? 2'd2 : 2'd1;
			else
				push.cnt = sec_v ? 2'd1 : 2'd0;
		end
		push.r0.last = (push.cnt == 2'd1);
		push.r1.last = 1'b1;
	end

	// next state
	always_comb begin
		logic go_idle;
		go_idle       = 1'b0;
		mode_n        = mode_q;
		pending_op_n  = pending_op_q;
		token_start_n = token_start_q;
		dot_count_n   = dot_count_q;
		position_n    = position_q;
		line_count_n  = line_count_q;
		char_value_n  = char_value_q;
		halted_n      = halted_q;
		last_pos_n    = last_pos_q;
		if (adv) begin
			if (end_of_text) begin
				if (((mode_q == M_NUM) && num_bad) || (mode_q == M_STR) ||
					(mode_q == M_STR_ESC)) begin
					halted_n = 1'b1;
					mode_n   = M_IDLE;
				end else begin
					mode_n        = M_IDLE;
					pending_op_n  = CH_NUL;
					token_start_n = '0;
					dot_count_n   = 2'd0;
					position_n    = '0;
					line_count_n  = POS_BITS'(1);
					char_value_n  = CH_NUL;
					last_pos_n    = '0;
				end
			end else begin
				unique case (mode_q)
					M_OP: begin
						if ((pending_op_q == CH_SLASH) && (ch == CH_SLASH))
							mode_n = M_COMMENT;
						else if ((pending_op_q != CH_SLASH) && (ch == CH_EQ))
							mode_n = M_IDLE;
						else
							go_idle = 1'b1;
					end
					M_IDENT: begin
						if (!is_alnum)
							go_idle = 1'b1;
					end
					M_NUM: begin
						if (is_digit || (ch == CH_DOT)) begin
							if ((ch == CH_DOT) && (dot_count_q < 2'd2))
								dot_count_n = dot_count_q + 2'd1;
						end else if (num_bad) begin
							halted_n = 1'b1;
							mode_n   = M_IDLE;
						end else begin
							go_idle = 1'b1;
						end
					end
					M_STR: begin
						if (ch == CH_BSLASH)
							mode_n = M_STR_ESC;
						else if (ch == CH_DQUOTE)
							mode_n = M_IDLE;
					end
					M_STR_ESC: begin
						mode_n = M_STR;
					end
					M_CHAR_OPEN: begin
						if (ch == CH_BSLASH) begin
							mode_n = M_CHAR_ESC;
						end else begin
							char_value_n = ch;
							mode_n       = M_CHAR_CLOSE;
						end
					end
					M_CHAR_ESC: begin
						char_value_n = unescape(ch);
						mode_n       = M_CHAR_CLOSE;
					end
					M_CHAR_CLOSE: begin
						mode_n = M_IDLE;
					end
					M_COMMENT: begin
						if (ch == CH_NL) begin
							line_count_n = line_inc;
							mode_n       = M_IDLE;
						end
					end
					default: begin
						go_idle = 1'b1;
					end
				endcase
				if (go_idle) begin
					mode_n        = idle_mode;
					pending_op_n  = idle_pend;
					token_start_n = idle_ts;
					dot_count_n   = idle_dot;
					char_value_n  = idle_char;
					line_count_n  = idle_line;
				end
				last_pos_n = position_q;
				position_n = sat_inc(position_q);
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= M_IDLE;
			pending_op_q  <= CH_NUL;
			token_start_q <= '0;
			dot_count_q   <= 2'd0;
			position_q    <= '0;
			line_count_q  <= POS_BITS'(1);
			char_value_q  <= CH_NUL;
			halted_q      <= 1'b0;
			last_pos_q    <= '0;
		end else begin
			mode_q        <= mode_n;
			pending_op_q  <= pending_op_n;
			token_start_q <= token_start_n;
			dot_count_q   <= dot_count_n;
			position_q    <= position_n;
			line_count_q  <= line_count_n;
			char_value_q  <= char_value_n;
			halted_q      <= halted_n;
			last_pos_q    <= last_pos_n;
		end
	end

	`STT_ASSERT_NEXT(a_halt_sticky, clk, arst_n, halted_q, halted_q, "halt released without reset")
	`STT_ASSERT_NOW(a_halt_silent, clk, arst_n, halted_q, push.cnt == 2'd0, "records pushed while halted")
	`STT_ASSERT_NEXT(a_eot_restart, clk, arst_n, adv && end_of_text, (position_q == '0) || halted_q, "end of text did not restart offsets")

endmodule

>>> hw/rtl/source_text_tokenizer_unit.sv
// ---------------------------------------------------------------------------
// source_text_tokenizer_unit
// streaming tokenizer: source bytes in, token, value and error records out
// ---------------------------------------------------------------------------
//  channel  dir  word                      payload
//  text     in   source byte or end mark   ch, end_of_text
//  tokens   out  one result record         record, kind, start_pos, end_pos,
//                                          line_no, value_byte, error_code, last
//
//  one byte per cycle while text.ready is high; a byte enters an input register,
//  then its records are written into a 4-entry result queue, and the first
//  record shows at the queue head
//  a byte that gives two records holds the rate only while the queue drains
//  one record per cycle; the queue takes a word only with two free entries
//  text.ready drops when the input register is full and the queue lacks room
//  reset clears offsets and halt flag, sets line count to 1; no clearing pass
// ---------------------------------------------------------------------------
module source_text_tokenizer_unit import stt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	stt_in_if.sink    text,
	stt_out_if.source tokens
);

	logic  valid_s1;
	byte_t ch_s1;
	logic  eot_s1;
	logic  space;
	push_t push;

	// input register, drained whenever the queue has room
	assign text.ready = !valid_s1 || space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			ch_s1  <= text.ch;
			eot_s1 <= text.end_of_text;
		end
	end

	stt_lexer u_lexer (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (valid_s1),
		.ch          (ch_s1),
		.end_of_text (eot_s1),
		.space       (space),
		.push        (push)
	);

	stt_result_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.space  (space),
		.tokens (tokens)
	);

endmodule
